// ----- rtl/sgcr_pkg.sv -----
// Shared types, constants and the 6x8 font table for the scaled glyph column rasterizer.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package sgcr_pkg;

	localparam int GLYPH_WIDTH   = 6;
	localparam int GLYPH_HEIGHT  = 8;
	localparam int SCREEN_WIDTH_DEFAULT  = 96;
	localparam int SCREEN_HEIGHT_DEFAULT = 64;

	localparam int COORD_W     = 8;
	localparam int MASK_W      = 48;
	localparam int MODE_W      = 3;
	localparam int SCALE_W     = 3;
	localparam int GLYPH_IDX_W = 7;
	localparam int COL_W       = 3;
	localparam int OFFSET_W    = 6;
	localparam int GLYPH_COUNT = 96;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CODE_NEWLINE   = 8'd10;
	localparam logic [7:0] CODE_FIRST     = 8'd32;
	localparam logic [7:0] CODE_LAST      = 8'd127;

	localparam logic       FUNC_DRAW      = 1'b0;
	localparam logic       FUNC_SET       = 1'b1;

	localparam logic [MODE_W-1:0] SIZE_1X1 = 3'd0;
	localparam logic [MODE_W-1:0] SIZE_2X1 = 3'd1;
	localparam logic [MODE_W-1:0] SIZE_1X2 = 3'd2;
	localparam logic [MODE_W-1:0] SIZE_2X2 = 3'd3;
	localparam logic [MODE_W-1:0] SIZE_6X6 = 3'd4;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 3'd1;
	localparam logic [SCALE_W-1:0] SCALE_TWO = 3'd2;
	localparam logic [SCALE_W-1:0] SCALE_SIX = 3'd6;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);

	typedef struct packed {
		logic [COORD_W-1:0]     x;
		logic [COORD_W-1:0]     y;
		logic [GLYPH_IDX_W-1:0] glyph;
		logic [SCALE_W-1:0]     scale_x;
		logic [SCALE_W-1:0]     scale_y;
	} job_t;

	// Columns 0 to 4 of each glyph, column 0 in the low byte; column 5 is always blank.
	localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
		40'h0000000000, 40'h00005F0000, 40'h0003040304, 40'h0A3F147E28,
		40'h122A7F2A24, 40'h6264081323, 40'h5026594E30, 40'h0001020000,
		40'h41221C0000, 40'h00001C2241, 40'h2214081422, 40'h08083E0808,
		40'h0000003050, 40'h0808080808, 40'h0000006060, 40'h0204081020,
		40'h3E4549513E, 40'h00407F4200, 40'h4649495162, 40'h3649494122,
		40'h107F121418, 40'h394545452F, 40'h324949493E, 40'h0305196101,
		40'h3649494936, 40'h3E49494926, 40'h0000363600, 40'h0000365600,
		40'h4122140800, 40'h1414141414, 40'h0008142241, 40'h0609590102,
		40'h2E555D413E, 40'h601C131C60, 40'h364949497F, 40'h224141413E,
		40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h3A4941221C,
		40'h7F0808087F, 40'h00417F4100, 40'h3F40404020, 40'h412214087F,
		40'h004040407F, 40'h7F0418047F, 40'h7F1008047F, 40'h3E4141413E,
		40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3249494926,
		40'h01017F0101, 40'h3F4040403F, 40'h031C601C03, 40'h0F700F700F,
		40'h4136083641, 40'h0102780601, 40'h4345495161, 40'h41417F0000,
		40'h11167C1615, 40'h00007F4141, 40'h0002010200, 40'h4040404040,
		40'h0000020100, 40'h7854542000, 40'h3844447F00, 40'h2844443800,
		40'h7F44443800, 40'h1854543800, 40'h01053E0400, 40'h3C54540800,
		40'h7804047F00, 40'h00007D0000, 40'h003D404000, 40'h4428107F00,
		40'h00007F0100, 40'h78047C047C, 40'h7804047C00, 40'h3844443800,
		40'h0814147C00, 40'h7C14140800, 40'h0404087C00, 40'h2454544800,
		40'h40443E0400, 40'h7C40403C00, 40'h0C10207C00, 40'h1C601C601C,
		40'h6C10106C00, 40'h1C30504C00, 40'h4C54644400, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000
	};

	function automatic logic [7:0] font_column(input logic [GLYPH_IDX_W-1:0] glyph,
			input logic [COL_W-1:0] col);
		logic [39:0] entry;
		logic [7:0]  bits;
		entry = (glyph < GLYPH_IDX_W'(GLYPH_COUNT)) ? FONT_ROM[glyph] : '0;
		unique case (col)
			3'd0: bits = entry[7:0];
			3'd1: bits = entry[15:8];
			3'd2: bits = entry[23:16];
			3'd3: bits = entry[31:24];
			3'd4: bits = entry[39:32];
			default: bits = 8'h00;
		endcase
		return bits;
	endfunction

	function automatic logic [SCALE_W-1:0] scale_x_of(input logic [MODE_W-1:0] mode);
		logic [SCALE_W-1:0] s;
		unique case (mode)
			SIZE_2X1, SIZE_2X2: s = SCALE_TWO;
			SIZE_6X6:           s = SCALE_SIX;
			default:            s = SCALE_ONE;
		endcase
		return s;
	endfunction

	function automatic logic [SCALE_W-1:0] scale_y_of(input logic [MODE_W-1:0] mode);
		logic [SCALE_W-1:0] s;
		unique case (mode)
			SIZE_1X2, SIZE_2X2: s = SCALE_TWO;
			SIZE_6X6:           s = SCALE_SIX;
			default:            s = SCALE_ONE;
		endcase
		return s;
	endfunction

	// Cursor advance after a character: the scaled glyph width.
	function automatic logic [COORD_W-1:0] advance_of(input logic [MODE_W-1:0] mode);
		logic [COORD_W-1:0] a;
		unique case (mode)
			SIZE_2X1, SIZE_2X2: a = COORD_W'(GLYPH_WIDTH * 2);
			SIZE_6X6:           a = COORD_W'(GLYPH_WIDTH * 6);
			default:            a = COORD_W'(GLYPH_WIDTH);
		endcase
		return a;
	endfunction

	// Repeats each glyph row bit scale_y times down the column.
	function automatic logic [MASK_W-1:0] expand_column(input logic [7:0] bits,
			input logic [SCALE_W-1:0] scale_y);
		logic [MASK_W-1:0] m;
		m = '0;
		unique case (scale_y)
			SCALE_TWO: begin
				for (int g = 0; g < 8; g++) begin
					m[2*g]   = bits[g];
					m[2*g+1] = bits[g];
				end
			end
			SCALE_SIX: begin
				for (int g = 0; g < 8; g++) begin
					for (int r = 0; r < 6; r++) begin
						m[6*g+r] = bits[g];
					end
				end
			end
			default: begin
				m[7:0] = bits;
			end
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/sgcr_cmd_if.sv -----
// Command channel of the rasterizer: character or set-cursor requests.
// Depends on sgcr_pkg for field widths.
interface sgcr_cmd_if;
	import sgcr_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic [7:0]         char_code;
	logic [COORD_W-1:0] cursor_column;
	logic [COORD_W-1:0] cursor_row;

	modport source (output valid, func, char_code, cursor_column, cursor_row, input ready);
	modport sink   (input valid, func, char_code, cursor_column, cursor_row, output ready);
endinterface

// ----- rtl/sgcr_pix_if.sv -----
// Result channel of the rasterizer: one scaled glyph column per request.
// Depends on sgcr_pkg for field widths.
interface sgcr_pix_if;
	import sgcr_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] column_x;
	logic [COORD_W-1:0] top_y;
	logic [MASK_W-1:0]  column_mask;
	logic               last;

	modport source (output valid, column_x, top_y, column_mask, last, input ready);
	modport sink   (input valid, column_x, top_y, column_mask, last, output ready);
endinterface

// ----- rtl/sgcr_cfg_if.sv -----
// Configuration write channel of the rasterizer: the glyph scale register.
// Depends on sgcr_pkg for the register width.
interface sgcr_cfg_if;
	import sgcr_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] size_mode;

	modport source (output valid, size_mode, input ready);
	modport sink   (input valid, size_mode, output ready);
endinterface

// ----- rtl/sgcr_front.sv -----
// Front end: holds the cursor and scale register, classifies requests and queues draw jobs.
// Depends on sgcr_pkg and the command and configuration interfaces.
module sgcr_front #(
	parameter int SCREEN_WIDTH  = sgcr_pkg::SCREEN_WIDTH_DEFAULT,
	parameter int SCREEN_HEIGHT = sgcr_pkg::SCREEN_HEIGHT_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	sgcr_cmd_if.sink          cmd,
	sgcr_cfg_if.sink          cfg,
	input  logic              queue_full,
	output logic              push,
	output sgcr_pkg::job_t    push_job
);
	import sgcr_pkg::*;

	typedef enum logic [1:0] {OP_IGNORE, OP_SET, OP_NEWLINE, OP_DRAW} op_t;

	localparam logic [COORD_W:0]   X_LIMIT = (COORD_W+1)'(SCREEN_WIDTH);
	localparam logic [COORD_W-1:0] Y_LIMIT = COORD_W'(SCREEN_HEIGHT - GLYPH_HEIGHT);

	logic [MODE_W-1:0]  size_mode_q;
	logic [COORD_W-1:0] cursor_x_q;
	logic [COORD_W-1:0] cursor_y_q;

	op_t                op;
	logic               accept;
	logic               wrap;
	logic [COORD_W-1:0] next_row;
	logic [COORD_W-1:0] draw_x;
	logic [COORD_W-1:0] draw_y;

	assign cmd.ready = !queue_full;
	assign cfg.ready = 1'b1;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		priority if (cmd.func == FUNC_SET) begin
			op = OP_SET;
		end else if (cmd.char_code == CODE_NEWLINE) begin
			op = OP_NEWLINE;
		end else if (cmd.char_code < CODE_FIRST || cmd.char_code > CODE_LAST) begin
			op = OP_IGNORE;
		end else begin
			op = OP_DRAW;
		end
	end

	// The edge test uses the unscaled glyph width, whatever the scale.
	always_comb begin
		next_row = cursor_y_q + COORD_W'(GLYPH_HEIGHT);
		wrap     = ({1'b0, cursor_x_q} + (COORD_W+1)'(GLYPH_WIDTH)) > X_LIMIT;
		draw_x   = wrap ? '0 : cursor_x_q;
		if (wrap) begin
			draw_y = (next_row >= Y_LIMIT) ? '0 : next_row;
		end else begin
			draw_y = cursor_y_q;
		end
	end

	assign push             = accept && (op == OP_DRAW);
	assign push_job.x       = draw_x;
	assign push_job.y       = draw_y;
	assign push_job.glyph   = GLYPH_IDX_W'(cmd.char_code - CODE_FIRST);
	assign push_job.scale_x = scale_x_of(size_mode_q);
	assign push_job.scale_y = scale_y_of(size_mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_mode_q <= SIZE_1X1;
			cursor_x_q  <= '0;
			cursor_y_q  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				size_mode_q <= cfg.size_mode;
			end
			if (accept) begin
				unique case (op)
					OP_SET: begin
						cursor_x_q <= cmd.cursor_column;
						cursor_y_q <= cmd.cursor_row;
					end
					OP_NEWLINE: begin
						cursor_x_q <= '0;
						cursor_y_q <= next_row;
					end
					OP_DRAW: begin
						cursor_x_q <= draw_x + advance_of(size_mode_q);
						cursor_y_q <= draw_y;
					end
					OP_IGNORE: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/sgcr_queue.sv -----
// Short job queue between the front end and the column generator.
// Depends on sgcr_pkg for the job type and queue depth.
module sgcr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sgcr_pkg::job_t    push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output sgcr_pkg::job_t    head
);
	import sgcr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sgcr_back.sv -----
// Column generator: walks the glyph columns of the head job and drives the result register.
// Depends on sgcr_pkg for the font table and scaling functions, and on the result interface.
module sgcr_back #(
	parameter int SCREEN_WIDTH  = sgcr_pkg::SCREEN_WIDTH_DEFAULT,
	parameter int SCREEN_HEIGHT = sgcr_pkg::SCREEN_HEIGHT_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  sgcr_pkg::job_t    head,
	output logic              pop,
	sgcr_pix_if.source        pix
);
	import sgcr_pkg::*;

	localparam logic [COORD_W:0]   X_END = (COORD_W+1)'(SCREEN_WIDTH);
	localparam logic [COORD_W:0]   Y_END = (COORD_W+1)'(SCREEN_HEIGHT);

	logic [COL_W-1:0]    col_q;
	logic [SCALE_W-1:0]  rep_q;
	logic [OFFSET_W-1:0] offset_q;

	logic               valid_q;
	logic [COORD_W-1:0] column_x_q;
	logic [COORD_W-1:0] top_y_q;
	logic [MASK_W-1:0]  column_mask_q;
	logic               last_q;

	logic               advance;
	logic               rep_done;
	logic               col_last;
	logic [COORD_W-1:0] x;
	logic [MASK_W-1:0]  row_ok;
	logic [MASK_W-1:0]  mask;

	assign advance  = head_valid && (!valid_q || pix.ready);
	assign rep_done = (rep_q == head.scale_x - 1'b1);
	assign col_last = rep_done && (col_q == LAST_COL);
	assign pop      = advance && col_last;
	assign x        = head.x + COORD_W'(offset_q);

	// Rows that wrap past 255 land at the top of the screen again, hence the per-bit test.
	always_comb begin
		for (int n = 0; n < MASK_W; n++) begin
			row_ok[n] = {1'b0, head.y + COORD_W'(n)} < Y_END;
		end
		if ({1'b0, x} < X_END) begin
			mask = expand_column(font_column(head.glyph, col_q), head.scale_y) & row_ok;
		end else begin
			mask = '0;
		end
	end

	assign pix.valid       = valid_q;
	assign pix.column_x    = column_x_q;
	assign pix.top_y       = top_y_q;
	assign pix.column_mask = column_mask_q;
	assign pix.last        = last_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			column_x_q    <= x;
			top_y_q       <= head.y;
			column_mask_q <= mask;
			last_q        <= col_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			col_q    <= '0;
			rep_q    <= '0;
			offset_q <= '0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
			end else if (pix.ready) begin
				valid_q <= 1'b0;
			end
			if (advance) begin
				if (col_last) begin
					col_q    <= '0;
					rep_q    <= '0;
					offset_q <= '0;
				end else begin
					offset_q <= offset_q + 1'b1;
					if (rep_done) begin
						rep_q <= '0;
						col_q <= col_q + 1'b1;
					end else begin
						rep_q <= rep_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/scaled_glyph_column_rasterizer.sv -----
// Top level of the scaled glyph column rasterizer: front end, job queue and column generator.
// Depends on sgcr_pkg, the three channel interfaces, sgcr_front, sgcr_queue and sgcr_back.
//
// Usage: cmd carries requests that either set the cursor (func 1) or present a character
// code (func 0). Newline moves the cursor to the start of the next text row; codes 32 to
// 127 are drawn; all other codes are dropped. cfg writes the 3-bit glyph scale register
// and is always ready; write it only while the block is idle.
// pix delivers one request per scaled glyph column: its x, the top row, a 48-bit mask
// and a last flag on the final column of the character.
// With the queue and the result register empty, a taken request is written into the job
// queue and then its first column into the result register, where it becomes valid.
// Throughput: 6 times the horizontal scale columns per character, one column per cycle
// while pix is ready, set by the column walker in the back end. Cursor moves overlap
// with drawing.
// cmd stays ready while the two-entry job queue has room, so requests keep flowing while
// earlier characters are still being drawn. When pix stalls, the result register holds
// and the back end stops; the queue then fills and cmd drops ready.
// Reset clears the cursor to (0, 0), the scale to 1x1 and empties the queue.
module scaled_glyph_column_rasterizer #(
	parameter int SCREEN_WIDTH  = sgcr_pkg::SCREEN_WIDTH_DEFAULT,
	parameter int SCREEN_HEIGHT = sgcr_pkg::SCREEN_HEIGHT_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	sgcr_cmd_if.sink   cmd,
	sgcr_cfg_if.sink   cfg,
	sgcr_pix_if.source pix
);
	import sgcr_pkg::*;

	logic queue_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head;

	sgcr_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	sgcr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sgcr_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.pix        (pix)
	);

endmodule

// ----- verif/tb_scaled_glyph_column_rasterizer.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for scaled_glyph_column_rasterizer: directed and random text requests
// at every glyph scale, checked column by column against an internal cursor and font model.
// Depends on sgcr_pkg, the three channel interfaces and the rasterizer RTL.
module tb_scaled_glyph_column_rasterizer;
	import sgcr_pkg::*;

	localparam int SCREEN_W = SCREEN_WIDTH_DEFAULT;
	localparam int SCREEN_H = SCREEN_HEIGHT_DEFAULT;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int STALL_CYCLES = 250;
	localparam int RANDOM_CHUNK = 14;

	// Scale codes with no defined size; the block treats them as 1x1.
	localparam logic [MODE_W-1:0] SIZE_SPARE_5 = 3'd5;
	localparam logic [MODE_W-1:0] SIZE_SPARE_6 = 3'd6;
	localparam logic [MODE_W-1:0] SIZE_SPARE_7 = 3'd7;

	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_BLANK_FIRST = 8'd123;

	// Font columns 0 to 4, column 0 in the top byte; column 5 is always blank.
	localparam logic [39:0] GLYPHS [96] = '{
		40'h0000000000, 40'h00005F0000, 40'h0403040300, 40'h287E143F0A,
		40'h242A7F2A12, 40'h2313086462, 40'h304E592650, 40'h0000020100,
		40'h00001C2241, 40'h41221C0000, 40'h2214081422, 40'h08083E0808,
		40'h5030000000, 40'h0808080808, 40'h6060000000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h6251494946, 40'h2241494936,
		40'h1814127F10, 40'h2F45454539, 40'h3E49494932, 40'h0161190503,
		40'h3649494936, 40'h264949493E, 40'h0036360000, 40'h0056360000,
		40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201590906,
		40'h3E415D552E, 40'h601C131C60, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h1C2241493A,
		40'h7F0808087F, 40'h00417F4100, 40'h204040403F, 40'h7F08142241,
		40'h7F40404000, 40'h7F0418047F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
		40'h01017F0101, 40'h3F4040403F, 40'h031C601C03, 40'h0F700F700F,
		40'h4136083641, 40'h0106780201, 40'h6151494543, 40'h00007F4141,
		40'h15167C1611, 40'h41417F0000, 40'h0002010200, 40'h4040404040,
		40'h0001020000, 40'h0020545478, 40'h007F444438, 40'h0038444428,
		40'h003844447F, 40'h0038545418, 40'h00043E0501, 40'h000854543C,
		40'h007F040478, 40'h00007D0000, 40'h0040403D00, 40'h007F102844,
		40'h00017F0000, 40'h7C047C0478, 40'h007C040478, 40'h0038444438,
		40'h007C141408, 40'h000814147C, 40'h007C080404, 40'h0048545424,
		40'h00043E4440, 40'h003C40407C, 40'h007C20100C, 40'h1C601C601C,
		40'h006C10106C, 40'h004C50301C, 40'h004464544C, 40'h0000000000,
		40'h0000000000, 40'h0000000000, 40'h0000000000, 40'h0000000000
	};

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [MASK_W-1:0]  mask;
		logic               last;
	} glyph_column_t;

	logic clk = 1'b0;
	logic arst_n;

	sgcr_cmd_if cmd();
	sgcr_cfg_if cfg();
	sgcr_pix_if pix();

	scaled_glyph_column_rasterizer #(
		.SCREEN_WIDTH(SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg),
		.pix(pix)
	);

	// Model state: cursor and scale register as the block should hold them.
	logic [COORD_W-1:0] cur_x;
	logic [COORD_W-1:0] cur_y;
	logic [MODE_W-1:0]  size_reg;
	glyph_column_t      expected_columns[$];

	int src_idle;
	int snk_idle;
	logic pix_hold;
	int fail_count;
	int quiet_cycles;
	int n_drawn, n_set, n_newline, n_dropped, n_columns;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Works out the columns one accepted request should produce and updates the cursor.
	task automatic predict_columns(input logic f, input logic [7:0] code,
			input logic [7:0] col, input logic [7:0] row);
		int sx, sy, c, r, n, px;
		logic [7:0] bits;
		logic [COORD_W-1:0] yy;
		logic [MASK_W-1:0] mask;
		if (f == FUNC_SET) begin
			cur_x = col;
			cur_y = row;
			n_set++;
			return;
		end
		if (code == CODE_NEWLINE) begin
			cur_x = '0;
			cur_y = cur_y + 8'(GLYPH_HEIGHT);
			n_newline++;
			return;
		end
		if (code < CODE_FIRST || code > CODE_LAST) begin
			n_dropped++;
			return;
		end
		n_drawn++;
		// The wrap test uses the unscaled width, whatever the scale.
		if (int'(cur_x) + GLYPH_WIDTH > SCREEN_W) begin
			cur_x = '0;
			cur_y = cur_y + 8'(GLYPH_HEIGHT);
			if (cur_y >= 8'(SCREEN_H - GLYPH_HEIGHT))
				cur_y = '0;
		end
		case (size_reg)
			SIZE_2X1: begin sx = 2; sy = 1; end
			SIZE_1X2: begin sx = 1; sy = 2; end
			SIZE_2X2: begin sx = 2; sy = 2; end
			SIZE_6X6: begin sx = 6; sy = 6; end
			default:  begin sx = 1; sy = 1; end
		endcase
		for (c = 0; c < GLYPH_WIDTH; c++) begin
			bits = (c < GLYPH_WIDTH - 1) ?
				GLYPHS[GLYPH_IDX_W'(code - CODE_FIRST)][39 - 8 * c -: 8] : 8'h00;
			for (r = 0; r < sx; r++) begin
				px = (int'(cur_x) + c * sx + r) % 256;
				mask = '0;
				if (px < SCREEN_W) begin
					for (n = 0; n < GLYPH_HEIGHT * sy; n++) begin
						yy = cur_y + 8'(n);
						if (bits[3'(n / sy)] && yy < 8'(SCREEN_H))
							mask[6'(n)] = 1'b1;
					end
				end
				expected_columns.push_back('{8'(px), cur_y, mask,
					(c == GLYPH_WIDTH - 1) && (r == sx - 1)});
			end
		end
		cur_x = cur_x + 8'(GLYPH_WIDTH * sx);
	endtask

	// Offers one request and returns at the edge that accepts it. Valid stays high
	// unless the next call decides to idle, so back-to-back requests need no gap.
	task automatic send_request(input logic f, input logic [7:0] code,
			input logic [7:0] col, input logic [7:0] row);
		while ($urandom_range(99) < src_idle) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.func <= f;
		cmd.char_code <= code;
		cmd.cursor_column <= col;
		cmd.cursor_row <= row;
		do @(posedge clk); while (!cmd.ready);
		predict_columns(f, code, col, row);
	endtask

	// Lets every expected column drain, then allows for requests that draw nothing.
	task automatic wait_idle();
		cmd.valid <= 1'b0;
		while (expected_columns.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [MODE_W-1:0] mode);
		wait_idle();
		cfg.valid <= 1'b1;
		cfg.size_mode <= mode;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		size_reg = mode;
	endtask

	task automatic test_reset_cursor_draw();
		send_request(FUNC_DRAW, "A", 8'h00, 8'h00);
		send_request(FUNC_DRAW, CHAR_SPACE, 8'hFF, 8'hFF);
		send_request(FUNC_DRAW, CODE_LAST, 8'h00, 8'h00);
		send_request(FUNC_DRAW, CHAR_BLANK_FIRST, 8'h00, 8'h00);
	endtask

	task automatic test_cursor_edges();
		// Last column that still fits, with the rows running off the bottom.
		send_request(FUNC_SET, 8'h00, 8'd90, 8'd60);
		send_request(FUNC_DRAW, "#", 8'h00, 8'h00);
		send_request(FUNC_DRAW, "~", 8'h00, 8'h00);
		// Wrap into the bottom text row sends the cursor back to the top.
		send_request(FUNC_SET, 8'hFF, 8'd91, 8'd48);
		send_request(FUNC_DRAW, "W", 8'h00, 8'h00);
		// Rows that wrap past 255 land on screen again.
		send_request(FUNC_SET, 8'h00, 8'd0, 8'd250);
		send_request(FUNC_DRAW, "@", 8'h00, 8'h00);
		send_request(FUNC_SET, 8'h00, 8'd255, 8'd255);
		send_request(FUNC_DRAW, "0", 8'h00, 8'h00);
		send_request(FUNC_DRAW, CODE_NEWLINE, 8'h00, 8'h00);
		send_request(FUNC_DRAW, "g", 8'h00, 8'h00);
	endtask

	task automatic test_ignored_codes();
		send_request(FUNC_DRAW, 8'd0, 8'hFF, 8'hFF);
		send_request(FUNC_DRAW, CODE_FIRST - 8'd1, 8'h00, 8'h00);
		send_request(FUNC_DRAW, CODE_LAST + 8'd1, 8'h00, 8'h00);
		send_request(FUNC_DRAW, 8'd255, 8'h00, 8'h00);
		send_request(FUNC_DRAW, "Z", 8'h00, 8'h00);
	endtask

	task automatic test_scale_extremes();
		write_size(SIZE_6X6);
		// Columns past the right edge and rows past the bottom are cleared.
		send_request(FUNC_SET, 8'h00, 8'd90, 8'd30);
		send_request(FUNC_DRAW, "M", 8'h00, 8'h00);
		write_size(SIZE_SPARE_7);
		send_request(FUNC_DRAW, "j", 8'h00, 8'h00);
	endtask

	task automatic test_random_text(input logic [MODE_W-1:0] mode, input int count);
		int k, pick;
		logic f;
		logic [7:0] code, col, row;
		write_size(mode);
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			f = FUNC_DRAW;
			code = 8'($urandom_range(32, 127));
			col = 8'($urandom);
			row = 8'($urandom);
			if (pick < 15) begin
				f = FUNC_SET;
				if ($urandom_range(1))
					col = 8'($urandom_range(84, 95));
				case ($urandom_range(2))
					0: row = 8'($urandom_range(40, 63));
					1: row = 8'($urandom_range(240, 255));
					default: ;
				endcase
			end else if (pick < 20) begin
				code = CODE_NEWLINE;
			end else if (pick < 30) begin
				code = $urandom_range(1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(128, 255));
			end
			send_request(f, code, col, row);
		end
	endtask

	// Output held off for a long stretch while requests keep coming, so the queue
	// fills and the command channel has to drop ready.
	task automatic test_output_stall();
		int k;
		write_size(SIZE_2X2);
		src_idle = 0;
		fork
			begin
				pix_hold <= 1'b1;
				repeat (STALL_CYCLES) @(posedge clk);
				pix_hold <= 1'b0;
			end
		join_none
		for (k = 0; k < 12; k++)
			send_request(FUNC_DRAW, 8'($urandom_range(33, 122)), 8'h00, 8'h00);
	endtask

	always @(posedge clk) begin
		if (pix_hold)
			pix.ready <= 1'b0;
		else
			pix.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin : check_columns
		glyph_column_t want;
		if (arst_n && pix.valid && pix.ready) begin
			n_columns++;
			if (expected_columns.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected column x=%0d y=%0d mask=%h last=%0b", $time,
					pix.column_x, pix.top_y, pix.column_mask, pix.last);
			end else begin
				want = expected_columns.pop_front();
				if (pix.column_x !== want.x) begin
					fail_count++;
					$display("%0t: column_x expected %0d actual %0d", $time, want.x, pix.column_x);
				end
				if (pix.top_y !== want.y) begin
					fail_count++;
					$display("%0t: top_y expected %0d actual %0d", $time, want.y, pix.top_y);
				end
				if (pix.column_mask !== want.mask) begin
					fail_count++;
					$display("%0t: column_mask expected %h actual %h", $time,
						want.mask, pix.column_mask);
				end
				if (pix.last !== want.last) begin
					fail_count++;
					$display("%0t: last expected %0b actual %0b", $time, want.last, pix.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd.valid && cmd.ready) || (pix.valid && pix.ready)
				|| (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no request accepted for %0d cycles, %0d columns outstanding",
				$time, QUIET_LIMIT, expected_columns.size());
			$display("[scaled_glyph_column_rasterizer] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.func = FUNC_DRAW;
		cmd.char_code = '0;
		cmd.cursor_column = '0;
		cmd.cursor_row = '0;
		cfg.valid = 1'b0;
		cfg.size_mode = SIZE_1X1;
		pix.ready = 1'b0;
		pix_hold = 1'b0;
		quiet_cycles = 0;
		fail_count = 0;
		n_drawn = 0;
		n_set = 0;
		n_newline = 0;
		n_dropped = 0;
		n_columns = 0;
		cur_x = '0;
		cur_y = '0;
		size_reg = SIZE_1X1;
		src_idle = 24;
		snk_idle = 87;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_cursor_draw();
		test_cursor_edges();
		test_ignored_codes();
		test_scale_extremes();
		test_random_text(SIZE_2X1, RANDOM_CHUNK);
		test_random_text(SIZE_1X2, RANDOM_CHUNK);
		test_random_text(SIZE_1X1, RANDOM_CHUNK);

		src_idle = 87;
		snk_idle = 24;
		test_random_text(SIZE_2X2, RANDOM_CHUNK);
		test_random_text(SIZE_6X6, RANDOM_CHUNK);
		test_random_text(SIZE_SPARE_6, RANDOM_CHUNK);

		src_idle = 0;
		snk_idle = 0;
		test_random_text(SIZE_SPARE_5, RANDOM_CHUNK);
		test_random_text(SIZE_6X6, RANDOM_CHUNK);
		test_random_text(SIZE_1X1, RANDOM_CHUNK);
		test_random_text(SIZE_2X1, RANDOM_CHUNK);
		test_output_stall();

		cmd.valid <= 1'b0;
		while (expected_columns.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d characters, %0d cursor moves, %0d newlines, %0d dropped codes",
			n_drawn, n_set, n_newline, n_dropped);
		$display("over all eight scale codes; %0d glyph columns checked.", n_columns);
		if (fail_count == 0) begin
			$display("[scaled_glyph_column_rasterizer] OK");
		end else begin
			$display("[scaled_glyph_column_rasterizer] ERROR");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sgcr_pkg.sv
rtl/sgcr_cmd_if.sv
rtl/sgcr_pix_if.sv
rtl/sgcr_cfg_if.sv
rtl/sgcr_front.sv
rtl/sgcr_queue.sv
rtl/sgcr_back.sv
rtl/scaled_glyph_column_rasterizer.sv
verif/tb_scaled_glyph_column_rasterizer.sv
